/* src/sts_pkg.sv */
`default_nettype none

package sts_pkg;

  // Counter, field and output widths
  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned LINE_BITS = 16;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned OUT_W     = 56;

  // Token kinds
  localparam logic [3:0] TK_IDENT    = 4'd0;
  localparam logic [3:0] TK_STRING   = 4'd1;
  localparam logic [3:0] TK_NUMBER   = 4'd2;
  localparam logic [3:0] TK_LBRACE   = 4'd3;
  localparam logic [3:0] TK_DLBRACE  = 4'd4;
  localparam logic [3:0] TK_RBRACE   = 4'd5;
  localparam logic [3:0] TK_DRBRACE  = 4'd6;
  localparam logic [3:0] TK_ARROW    = 4'd7;
  localparam logic [3:0] TK_COLON    = 4'd8;
  localparam logic [3:0] TK_COMMA    = 4'd9;
  localparam logic [3:0] TK_LPAREN   = 4'd10;
  localparam logic [3:0] TK_RPAREN   = 4'd11;
  localparam logic [3:0] TK_LBRACKET = 4'd12;
  localparam logic [3:0] TK_RBRACKET = 4'd13;
  localparam logic [3:0] TK_ERROR    = 4'd14;
  localparam logic [3:0] TK_EOT      = 4'd15;

  // Error kinds
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;

  // Input item kinds
  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_EOT  = 1'b1;

  // Characters
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;

  typedef struct packed {
    logic [3:0]         kind;
    logic [1:0]         err;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic               last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_cont(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT) ||
           (c == CH_HASH) || (c == CH_DASH);
  endfunction

  function automatic token_t mk_tok(input logic [3:0] kind, input logic [1:0] err,
                                    input logic [FIELD_W-1:0] start,
                                    input logic [FIELD_W-1:0] len,
                                    input logic [FIELD_W-1:0] line);
    token_t t;
    t.kind  = kind;
    t.err   = err;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

/* src/script_token_scanner.sv */
`default_nettype none

// Streaming lexer for a small script notation.
// Input channel (s_axis): one request per source byte, tdata = char_code,
// tuser = kind (0 source byte, 1 end of text). End of text flushes any
// pending token, emits an end token and returns the scanner to offset 0,
// line 1, so the next byte starts a new text.
// Output channel (m_axis): one request per token, tlast marks the final
// token caused by one input request.
// Tokens caused by a byte are registered and appear in the cycle after it is accepted.
// Throughput: one input per cycle while the receiver is ready and each input
// yields at most one token; an input yielding k tokens occupies the
// three-entry result buffer until all k are taken. Input is taken whenever the
// result buffer is empty or drains in the same cycle, so a stalled receiver
// holds up input only once the buffer holds tokens it has not taken.
// Reset: asynchronous, clears the scan state and empties the result buffer.
module script_token_scanner
  import sts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] char_code
  input  wire logic             s_axis_tuser,   // [0] kind
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // [3:0] token_kind, [5:4] error_kind,
                                                // [21:6] token_start,
                                                // [37:22] token_length,
                                                // [53:38] line_number, [55:54] zero
  output logic                  m_axis_tlast    // last
);

  // Scan modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_IDENT    = 4'd1;
  localparam logic [3:0] M_NUMBER   = 4'd2;
  localparam logic [3:0] M_NUMDOT   = 4'd3;
  localparam logic [3:0] M_FRACTION = 4'd4;
  localparam logic [3:0] M_STRING   = 4'd5;
  localparam logic [3:0] M_LBRACE   = 4'd6;
  localparam logic [3:0] M_RBRACE   = 4'd7;
  localparam logic [3:0] M_DASH     = 4'd8;

  localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  // Scan state
  logic [3:0]           mode_q, mode_d;
  logic                 quote_q, quote_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [POS_BITS-1:0]  start_q, start_d;
  logic [POS_BITS-1:0]  dot_q, dot_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  // Result buffer: slot 0 drives the output
  token_t     slot_q [3];
  logic [1:0] cnt_q, cnt_d;

  token_t     tok [3];
  logic [1:0] n_tok;
  logic       in_acc, out_acc, do_idle;
  logic [7:0] c;
  logic [FIELD_W-1:0] ln;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign c       = s_axis_tdata;
  assign ln      = FIELD_W'(line_q);

  // Take a request only when the buffer is empty by the end of this cycle
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);

  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    pos_d   = pos_q;
    start_d = start_q;
    dot_d   = dot_q;
    line_d  = line_q;
    do_idle = 1'b0;
    n_tok   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      tok[i] = '0;
    end

    if (in_acc) begin
      if (s_axis_tuser == IN_EOT) begin
        // Flush pending token, then the end token
        case (mode_q)
          M_IDENT: begin
            tok[n_tok] = mk_tok(TK_IDENT, ERR_NONE, start_q, FIELD_W'(pos_q - start_q), ln);
            n_tok = n_tok + 2'd1;
          end
          M_NUMBER, M_FRACTION: begin
            tok[n_tok] = mk_tok(TK_NUMBER, ERR_NONE, start_q, FIELD_W'(pos_q - start_q), ln);
            n_tok = n_tok + 2'd1;
          end
          M_NUMDOT: begin
            tok[n_tok] = mk_tok(TK_NUMBER, ERR_NONE, start_q, FIELD_W'(dot_q - start_q), ln);
            n_tok = n_tok + 2'd1;
            tok[n_tok] = mk_tok(TK_IDENT, ERR_NONE, dot_q, FIELD_W'(pos_q - dot_q), ln);
            n_tok = n_tok + 2'd1;
          end
          M_STRING: begin
            tok[n_tok] = mk_tok(TK_ERROR, ERR_UNTERM, start_q, FIELD_W'(pos_q - start_q), ln);
            n_tok = n_tok + 2'd1;
          end
          M_LBRACE: begin
            tok[n_tok] = mk_tok(TK_LBRACE, ERR_NONE, start_q, FIELD_W'(1), ln);
            n_tok = n_tok + 2'd1;
          end
          M_RBRACE: begin
            tok[n_tok] = mk_tok(TK_RBRACE, ERR_NONE, start_q, FIELD_W'(1), ln);
            n_tok = n_tok + 2'd1;
          end
          M_DASH: begin
            tok[n_tok] = mk_tok(TK_ERROR, ERR_UNEXPECTED, start_q, FIELD_W'(1), ln);
            n_tok = n_tok + 2'd1;
          end
          default: begin
          end
        endcase
        tok[n_tok] = mk_tok(TK_EOT, ERR_NONE, pos_q, FIELD_W'(0), ln);
        n_tok = n_tok + 2'd1;
        // Return to reset state
        mode_d  = M_IDLE;
        quote_d = 1'b0;
        pos_d   = '0;
        start_d = '0;
        dot_d   = '0;
        line_d  = LINE_BITS'(1);
      end else begin
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_BITS'(1);
        end
        // Finish or extend the token in progress
        case (mode_q)
          M_IDLE: do_idle = 1'b1;
          M_IDENT: begin
            if (!is_ident_cont(c)) begin
              tok[n_tok] = mk_tok(TK_IDENT, ERR_NONE, start_q, FIELD_W'(pos_q - start_q), ln);
              n_tok = n_tok + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_NUMBER: begin
            if (c == CH_DOT) begin
              dot_d  = pos_q;
              mode_d = M_NUMDOT;
            end else if (!is_digit(c)) begin
              tok[n_tok] = mk_tok(TK_NUMBER, ERR_NONE, start_q, FIELD_W'(pos_q - start_q), ln);
              n_tok = n_tok + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_NUMDOT: begin
            if (is_digit(c)) begin
              mode_d = M_FRACTION;
            end else begin
              // Number ends before the dot; an identifier starts at the dot
              tok[n_tok] = mk_tok(TK_NUMBER, ERR_NONE, start_q, FIELD_W'(dot_q - start_q), ln);
              n_tok = n_tok + 2'd1;
              start_d = dot_q;
              mode_d  = M_IDENT;
              if (!is_ident_cont(c)) begin
                tok[n_tok] = mk_tok(TK_IDENT, ERR_NONE, dot_q, FIELD_W'(pos_q - dot_q), ln);
                n_tok = n_tok + 2'd1;
                do_idle = 1'b1;
              end
            end
          end
          M_FRACTION: begin
            if (!is_digit(c)) begin
              tok[n_tok] = mk_tok(TK_NUMBER, ERR_NONE, start_q, FIELD_W'(pos_q - start_q), ln);
              n_tok = n_tok + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_STRING: begin
            if (c == (quote_q ? CH_SQUOTE : CH_DQUOTE)) begin
              tok[n_tok] = mk_tok(TK_STRING, ERR_NONE, start_q,
                                  FIELD_W'(pos_q + POS_BITS'(1) - start_q), ln);
              n_tok = n_tok + 2'd1;
              mode_d = M_IDLE;
            end else if ((c == CH_LF) && (line_q != LINE_MAX)) begin
              line_d = line_q + LINE_BITS'(1);
            end
          end
          M_LBRACE: begin
            mode_d = M_IDLE;
            if (c == CH_LBRACE) begin
              tok[n_tok] = mk_tok(TK_DLBRACE, ERR_NONE, start_q, FIELD_W'(2), ln);
              n_tok = n_tok + 2'd1;
            end else begin
              tok[n_tok] = mk_tok(TK_LBRACE, ERR_NONE, start_q, FIELD_W'(1), ln);
              n_tok = n_tok + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_RBRACE: begin
            mode_d = M_IDLE;
            if (c == CH_RBRACE) begin
              tok[n_tok] = mk_tok(TK_DRBRACE, ERR_NONE, start_q, FIELD_W'(2), ln);
              n_tok = n_tok + 2'd1;
            end else begin
              tok[n_tok] = mk_tok(TK_RBRACE, ERR_NONE, start_q, FIELD_W'(1), ln);
              n_tok = n_tok + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_DASH: begin
            mode_d = M_IDLE;
            if (c == CH_GT) begin
              tok[n_tok] = mk_tok(TK_ARROW, ERR_NONE, start_q, FIELD_W'(2), ln);
              n_tok = n_tok + 2'd1;
            end else begin
              tok[n_tok] = mk_tok(TK_ERROR, ERR_UNEXPECTED, start_q, FIELD_W'(1), ln);
              n_tok = n_tok + 2'd1;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // Scan the byte afresh from the idle mode
        if (do_idle) begin
          mode_d  = M_IDLE;
          start_d = pos_q;
          if ((c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB)) begin
            mode_d = M_IDLE;
          end else if (c == CH_LF) begin
            if (line_q != LINE_MAX) begin
              line_d = line_q + LINE_BITS'(1);
            end
          end else if (is_letter(c) || (c == CH_DOT) || (c == CH_HASH)) begin
            mode_d = M_IDENT;
          end else if (is_digit(c)) begin
            mode_d = M_NUMBER;
          end else begin
            case (c)
              CH_LBRACE: mode_d = M_LBRACE;
              CH_RBRACE: mode_d = M_RBRACE;
              CH_DASH:   mode_d = M_DASH;
              CH_COLON: begin
                tok[n_tok] = mk_tok(TK_COLON, ERR_NONE, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
              CH_COMMA: begin
                tok[n_tok] = mk_tok(TK_COMMA, ERR_NONE, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
              CH_LPAREN: begin
                tok[n_tok] = mk_tok(TK_LPAREN, ERR_NONE, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
              CH_RPAREN: begin
                tok[n_tok] = mk_tok(TK_RPAREN, ERR_NONE, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
              CH_LBRACKET: begin
                tok[n_tok] = mk_tok(TK_LBRACKET, ERR_NONE, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
              CH_RBRACKET: begin
                tok[n_tok] = mk_tok(TK_RBRACKET, ERR_NONE, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
              CH_DQUOTE, CH_SQUOTE: begin
                quote_d = (c == CH_SQUOTE);
                mode_d  = M_STRING;
              end
              default: begin
                tok[n_tok] = mk_tok(TK_ERROR, ERR_UNEXPECTED, pos_q, FIELD_W'(1), ln);
                n_tok = n_tok + 2'd1;
              end
            endcase
          end
        end
      end
    end

    // Mark the final token of this request
    for (int i = 0; i < 3; i++) begin
      tok[i].last = (n_tok != 2'd0) && (2'(i) == (n_tok - 2'd1));
    end
  end

  // Buffer occupancy: load on accept (buffer is then draining), else pop
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = n_tok;
    end else if (out_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      quote_q <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
      dot_q   <= '0;
      line_q  <= LINE_BITS'(1);
      cnt_q   <= 2'd0;
    end else begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      dot_q   <= dot_d;
      line_q  <= line_d;
      cnt_q   <= cnt_d;
    end
  end

  // Token payload: load fresh tokens, or advance the queue on a pop
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q[0] <= tok[0];
      slot_q[1] <= tok[1];
      slot_q[2] <= tok[2];
    end else if (out_acc) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {2'b00, slot_q[0].line, slot_q[0].len, slot_q[0].start,
                          slot_q[0].err, slot_q[0].kind};
  assign m_axis_tlast  = slot_q[0].last;

`ifndef SYNTHESIS
  a_last_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> cnt_q == 2'd1)
    else $error("tlast on a token that is not the tail of the buffer");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_acc))
    else $error("request taken while undelivered tokens remain");

  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == IN_EOT) |=>
      (mode_q == M_IDLE) && (pos_q == '0) && (line_q == LINE_BITS'(1)) && (cnt_q != 2'd0))
    else $error("end of text did not restart the scanner");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned CALM_FROM = 200;
  localparam int unsigned CALM_TO = 420;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // One source request: kind then the byte
  typedef struct packed {
    logic       kind;
    logic [7:0] code;
  } src_item_t;

  // Scanner modes of the lexer model kept in the bench
  typedef enum logic [3:0] {
    LX_IDLE, LX_NAME, LX_INT, LX_INT_DOT, LX_FRAC, LX_QUOTED,
    LX_OPEN, LX_CLOSE, LX_MINUS
  } lex_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;

  src_item_t src_pending_q[$];
  token_t    token_expect_q[$];

  // Lexer model state
  lex_mode_e   lx_mode = LX_IDLE;
  logic        lx_single = 1'b0;
  logic [15:0] lx_pos = '0;
  logic [15:0] lx_start = '0;
  logic [15:0] lx_line = 16'd1;
  logic [15:0] lx_dot = '0;
  token_t      lx_batch [0:2];
  int          lx_batch_n;

  string PUNCT_SET [0:11] = '{"{", "{{", "}", "}}", "->", ":", ",", "(", ")", "[", "]", "-"};

  script_token_scanner DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Character classes, ASCII only
  // ---------------------------------------------------------------------------
  function automatic logic char_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic char_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_name(input logic [7:0] c);
    return char_alpha(c) || char_digit(c) || c == CH_UNDER || c == CH_DOT ||
           c == CH_HASH || c == CH_DASH;
  endfunction

  // ---------------------------------------------------------------------------
  // Lexer model: fills lx_batch with the tokens one request causes
  // ---------------------------------------------------------------------------
  task automatic add_token(input logic [3:0] kind, input logic [1:0] err,
                           input logic [15:0] start, input logic [15:0] len);
    token_t t;
    if (lx_batch_n < 3) begin
      t.kind  = kind;
      t.err   = err;
      t.start = start;
      t.len   = len;
      t.line  = lx_line;
      t.last  = 1'b0;
      lx_batch[lx_batch_n] = t;
      lx_batch_n++;
    end
  endtask

  task automatic bump_line();
    if (lx_line != CNT_MAX) lx_line++;
  endtask

  // A byte seen between tokens: open a new token or emit a single mark
  task automatic lex_fresh(input logic [7:0] c, input logic [15:0] p);
    lx_start = p;
    if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
    end else if (c == CH_LF) begin
      bump_line();
    end else if (char_alpha(c) || c == CH_DOT || c == CH_HASH) begin
      lx_mode = LX_NAME;
    end else if (char_digit(c)) begin
      lx_mode = LX_INT;
    end else begin
      case (c)
        CH_LBRACE:   lx_mode = LX_OPEN;
        CH_RBRACE:   lx_mode = LX_CLOSE;
        CH_DASH:     lx_mode = LX_MINUS;
        CH_COLON:    add_token(TK_COLON, ERR_NONE, p, 16'd1);
        CH_COMMA:    add_token(TK_COMMA, ERR_NONE, p, 16'd1);
        CH_LPAREN:   add_token(TK_LPAREN, ERR_NONE, p, 16'd1);
        CH_RPAREN:   add_token(TK_RPAREN, ERR_NONE, p, 16'd1);
        CH_LBRACKET: add_token(TK_LBRACKET, ERR_NONE, p, 16'd1);
        CH_RBRACKET: add_token(TK_RBRACKET, ERR_NONE, p, 16'd1);
        CH_DQUOTE, CH_SQUOTE: begin
          lx_single = (c == CH_SQUOTE);
          lx_mode   = LX_QUOTED;
        end
        default:     add_token(TK_ERROR, ERR_UNEXPECTED, p, 16'd1);
      endcase
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [15:0] p;
    logic        again;
    int          guard;
    p = lx_pos;
    again = 1'b1;
    guard = 0;
    // A byte that ends a token is scanned again from the idle mode
    while (again && guard < 4) begin
      again = 1'b0;
      guard++;
      case (lx_mode)
        LX_IDLE: lex_fresh(c, p);
        LX_NAME: begin
          if (!char_name(c)) begin
            add_token(TK_IDENT, ERR_NONE, lx_start, p - lx_start);
            lx_mode = LX_IDLE;
            again = 1'b1;
          end
        end
        LX_INT: begin
          if (c == CH_DOT) begin
            lx_dot  = p;
            lx_mode = LX_INT_DOT;
          end else if (!char_digit(c)) begin
            add_token(TK_NUMBER, ERR_NONE, lx_start, p - lx_start);
            lx_mode = LX_IDLE;
            again = 1'b1;
          end
        end
        LX_INT_DOT: begin
          if (char_digit(c)) begin
            lx_mode = LX_FRAC;
          end else begin
            // Dot without a digit after it: split into number and name
            add_token(TK_NUMBER, ERR_NONE, lx_start, lx_dot - lx_start);
            lx_start = lx_dot;
            lx_mode  = LX_NAME;
            again = 1'b1;
          end
        end
        LX_FRAC: begin
          if (!char_digit(c)) begin
            add_token(TK_NUMBER, ERR_NONE, lx_start, p - lx_start);
            lx_mode = LX_IDLE;
            again = 1'b1;
          end
        end
        LX_QUOTED: begin
          if (c == (lx_single ? CH_SQUOTE : CH_DQUOTE)) begin
            add_token(TK_STRING, ERR_NONE, lx_start, p + 16'd1 - lx_start);
            lx_mode = LX_IDLE;
          end else if (c == CH_LF) begin
            bump_line();
          end
        end
        LX_OPEN: begin
          lx_mode = LX_IDLE;
          if (c == CH_LBRACE) begin
            add_token(TK_DLBRACE, ERR_NONE, lx_start, 16'd2);
          end else begin
            add_token(TK_LBRACE, ERR_NONE, lx_start, 16'd1);
            again = 1'b1;
          end
        end
        LX_CLOSE: begin
          lx_mode = LX_IDLE;
          if (c == CH_RBRACE) begin
            add_token(TK_DRBRACE, ERR_NONE, lx_start, 16'd2);
          end else begin
            add_token(TK_RBRACE, ERR_NONE, lx_start, 16'd1);
            again = 1'b1;
          end
        end
        LX_MINUS: begin
          lx_mode = LX_IDLE;
          if (c == CH_GT) begin
            add_token(TK_ARROW, ERR_NONE, lx_start, 16'd2);
          end else begin
            add_token(TK_ERROR, ERR_UNEXPECTED, lx_start, 16'd1);
            again = 1'b1;
          end
        end
        default: begin
          lx_mode = LX_IDLE;
          again = 1'b1;
        end
      endcase
    end
    if (lx_pos != CNT_MAX) lx_pos++;
  endtask

  // End of text: flush the open token, add the end token, rewind
  task automatic lex_finish();
    logic [15:0] p;
    p = lx_pos;
    case (lx_mode)
      LX_NAME:        add_token(TK_IDENT, ERR_NONE, lx_start, p - lx_start);
      LX_INT, LX_FRAC: add_token(TK_NUMBER, ERR_NONE, lx_start, p - lx_start);
      LX_INT_DOT: begin
        add_token(TK_NUMBER, ERR_NONE, lx_start, lx_dot - lx_start);
        add_token(TK_IDENT, ERR_NONE, lx_dot, p - lx_dot);
      end
      LX_QUOTED:      add_token(TK_ERROR, ERR_UNTERM, lx_start, p - lx_start);
      LX_OPEN:        add_token(TK_LBRACE, ERR_NONE, lx_start, 16'd1);
      LX_CLOSE:       add_token(TK_RBRACE, ERR_NONE, lx_start, 16'd1);
      LX_MINUS:       add_token(TK_ERROR, ERR_UNEXPECTED, lx_start, 16'd1);
      default: ;
    endcase
    add_token(TK_EOT, ERR_NONE, p, 16'd0);
    lx_mode   = LX_IDLE;
    lx_single = 1'b0;
    lx_pos    = '0;
    lx_start  = '0;
    lx_line   = 16'd1;
    lx_dot    = '0;
  endtask

  // Work out the tokens of one accepted request and queue them for checking
  task automatic predict_tokens(input logic kind, input logic [7:0] code);
    lx_batch_n = 0;
    if (kind == IN_EOT) lex_finish();
    else lex_byte(code);
    if (lx_batch_n > 0) lx_batch[lx_batch_n - 1].last = 1'b1;
    for (int i = 0; i < lx_batch_n; i++) token_expect_q.push_back(lx_batch[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] c);
    src_item_t it;
    it.kind = IN_CHAR;
    it.code = c;
    src_pending_q.push_back(it);
  endtask

  task automatic queue_eot();
    src_item_t it;
    it.kind = IN_EOT;
    it.code = 8'($urandom);  // ignored by the scanner, so scramble it
    src_pending_q.push_back(it);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) != 0) ? 8'("a" + $urandom_range(25))
                                     : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(5))
      0:       return rand_digit();
      1:       return CH_UNDER;
      2:       return CH_DOT;
      3:       return CH_HASH;
      4:       return CH_DASH;
      default: return rand_letter();
    endcase
  endfunction

  // Mostly well-formed tokens with random content, some noise and cut texts
  task automatic queue_random_token();
    int          pick;
    logic [7:0]  qc;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 14) begin
      case ($urandom_range(3))
        0:       queue_byte(CH_DOT);
        1:       queue_byte(CH_HASH);
        default: queue_byte(rand_letter());
      endcase
      repeat ($urandom_range(5)) queue_byte(rand_name_char());
    end else if (pick < 28) begin
      repeat ($urandom_range(1, 4)) queue_byte(rand_digit());
      case ($urandom_range(2))
        1: begin
          queue_byte(CH_DOT);
          repeat ($urandom_range(1, 3)) queue_byte(rand_digit());
        end
        2: queue_byte(CH_DOT);  // let the next token decide the dot
        default: ;
      endcase
    end else if (pick < 40) begin
      qc = ($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE;
      queue_byte(qc);
      repeat ($urandom_range(4)) begin
        b = ($urandom_range(3) == 0) ? CH_LF : 8'($urandom_range(255));
        if (b == qc) b = CH_SPACE;
        queue_byte(b);
      end
      if ($urandom_range(7) != 0) queue_byte(qc);  // leave a few open
    end else if (pick < 64) begin
      queue_text(PUNCT_SET[$urandom_range(11)]);
    end else if (pick < 84) begin
      case ($urandom_range(3))
        0:       queue_byte(CH_TAB);
        1:       queue_byte(CH_CR);
        2:       queue_byte(CH_LF);
        default: queue_byte(CH_SPACE);
      endcase
    end else if (pick < 94) begin
      queue_byte(8'($urandom_range(255)));
    end else begin
      queue_eot();
    end
  endtask

  // Idle with a probability of 35 percent, except within the calm window
  function automatic logic take_gap();
    if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  // ---------------------------------------------------------------------------
  // Cycle counter and timeout
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("script_token_scanner test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present pending requests, predict each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    src_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tuser, s_axis_tdata);
      // Advance only when the slot is free; hold the request otherwise
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_pending_q.size() > 0 && !take_gap()) begin
          it = src_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.code;
          s_axis_tuser  <= it.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each token taken with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_expect_q.size() == 0) begin
          $error("token with nothing expected: kind %0d start %0d",
                 m_axis_tdata[3:0], m_axis_tdata[21:6]);
          fail_cnt++;
        end else begin
          want = token_expect_q.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(m_axis_tdata[3:0]));
          check_field("error_kind", 32'(want.err), 32'(m_axis_tdata[5:4]));
          check_field("token_start", 32'(want.start), 32'(m_axis_tdata[21:6]));
          check_field("token_length", 32'(want.len), 32'(m_axis_tdata[37:22]));
          check_field("line_number", 32'(want.line), 32'(m_axis_tdata[53:38]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
        end
      end
    end
    m_axis_tready <= rst_ni && !take_gap();
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned base;

    // Every pair and single mark, brace split by a space, lone dash,
    // fraction, digits then dot then a letter, then bytes outside the classes
    queue_text("{{}}->{ }:,()[]-3.5 7.q");
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_eot();
    // Single-quoted string holding a double quote and a line feed,
    // then a double-quoted string left open at end of text
    queue_text("'a\"\n' \"b");
    queue_eot();
    // Brace, dash and dot still pending at end of text
    queue_text("{");
    queue_eot();
    queue_text("-");
    queue_eot();
    queue_text("5.");
    queue_eot();

    base = src_pending_q.size();
    while (src_pending_q.size() - base < RANDOM_ITEMS) queue_random_token();
    queue_eot();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every token has come back
    @(posedge clk_i);
    while (src_pending_q.size() > 0 || s_axis_tvalid || token_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (token_expect_q.size() > 0) begin
      $error("%0d expected tokens never arrived", token_expect_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("script_token_scanner test passed");
    end else begin
      $display("script_token_scanner test failed");
    end
    $finish;
  end

endmodule
